// ===== rtl/lis_pkg.sv =====
// shared types and constants for the longest increasing subsequence block
package lis_pkg;

   localparam int unsigned VALUE_W       = 32;
   localparam int unsigned RUN_W         = 10;
   localparam int unsigned MAX_ITEMS_DEF = 512;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      first;
   } req_type;

   typedef struct packed {
      logic [RUN_W-1:0] run_length;
      logic             overflow;
   } rsp_type;

endpackage

// ===== rtl/lis_length_per_element_top.sv =====
// per-element longest strictly increasing subsequence length, one shared compare unit
//
// Input beats on req_ carry a signed 32-bit value and a first flag; first starts a
// new sequence and drops every stored element. For each input beat one response beat
// on rsp_ carries the length of the longest strictly increasing subsequence that ends
// at that value, or overflow with length 0 when the store already holds MAX_ITEMS
// elements. Every stored element is revisited by one compare unit, one element per
// cycle, reading the value and length memories through a registered read port.
// From accept, an item passes through the scan state, one step per stored element,
// then through the drain and done states before response valid; a first or overflow
// beat goes straight from idle to the done state. The sequencer returns to idle as
// the response is registered, so the next item can be taken while that response is
// valid; the scan covers every stored element, up to MAX_ITEMS. req_ready is high only while the
// sequencer is idle; one item is in work at a time.
// The response sits in an output register, so a new item is taken while an earlier
// response still waits; if the receiver stalls, the finished item holds in its last
// step until the output register frees up, and no further item is taken.
// Reset clears the stored count and drops any pending response; memory contents are
// not cleared, only entries below the count are ever read.
module lis_length_per_element_top #(
   parameter int unsigned MAX_ITEMS = lis_pkg::MAX_ITEMS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lis_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lis_pkg::rsp_type rsp_payload
);
   import lis_pkg::*;

   localparam int unsigned IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int unsigned LEN_W = CNT_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [IDX_W-1:0]          rd_addr_ff, rd_addr_in;
   logic                      rd_valid_ff, rd_valid_in;
   logic signed [VALUE_W-1:0] val_ff, val_in;
   logic [LEN_W-1:0]          best_ff, best_in;
   logic                      ovf_ff, ovf_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   logic signed [VALUE_W-1:0] val_mem [MAX_ITEMS];
   logic [LEN_W-1:0]          len_mem [MAX_ITEMS];
   logic signed [VALUE_W-1:0] rd_val_ff;
   logic [LEN_W-1:0]          rd_len_ff;

   logic                      req_fire;
   logic                      out_free;
   logic                      finish;
   logic                      last_read;
   logic [CNT_W-1:0]          base_count;
   logic [LEN_W-1:0]          new_len;

   assign req_ready   = (state_ff == ST_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign finish      = (state_ff == ST_DONE) && out_free;
   assign last_read   = (CNT_W'(rd_addr_ff) + CNT_W'(1)) == count_ff;
   assign base_count  = req_payload.first ? '0 : count_ff;
   assign new_len     = best_ff + LEN_W'(1);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rd_addr_in   = rd_addr_ff;
      rd_valid_in  = 1'b0;
      val_in       = val_ff;
      best_in      = best_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      // compare unit: one stored element per cycle
      if (rd_valid_ff && (rd_val_ff < val_ff) && (rd_len_ff > best_ff)) begin
         best_in = rd_len_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               count_in   = base_count;
               val_in     = req_payload.value;
               best_in    = '0;
               rd_addr_in = '0;
               ovf_in     = (base_count == CNT_W'(MAX_ITEMS));
               if (base_count == '0 || base_count == CNT_W'(MAX_ITEMS)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            rd_valid_in = 1'b1;
            rd_addr_in  = rd_addr_ff + IDX_W'(1);
            if (last_read) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (ovf_ff) begin
                  rsp_in.run_length = '0;
                  rsp_in.overflow   = 1'b1;
               end else begin
                  rsp_in.run_length = RUN_W'(new_len);
                  rsp_in.overflow   = 1'b0;
                  count_in          = count_ff + CNT_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_addr_ff <= rd_addr_in;
      val_ff     <= val_in;
      best_ff    <= best_in;
      ovf_ff     <= ovf_in;
      rsp_ff     <= rsp_in;
   end

   // element store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (finish && !ovf_ff) begin
         val_mem[count_ff[IDX_W-1:0]] <= val_ff;
         len_mem[count_ff[IDX_W-1:0]] <= new_len;
      end
      rd_val_ff <= val_mem[rd_addr_ff];
      rd_len_ff <= len_mem[rd_addr_ff];
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ITEMS))
      else $error("stored count beyond capacity");

   a_first_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_payload.first |=> count_ff == '0)
      else $error("first beat did not empty the store");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> CNT_W'(rd_addr_ff) < count_ff)
      else $error("scan read past stored elements");

   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.overflow |-> rsp_ff.run_length == '0)
      else $error("overflow response with nonzero length");

   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.overflow |-> rsp_ff.run_length != '0)
      else $error("stored element reported zero length");

endmodule

// ===== test/tb_lis_length_per_element_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the per-element longest increasing subsequence block
module tb_lis_length_per_element_top;
   import lis_pkg::*;

   localparam int unsigned MAX_ITEMS   = MAX_ITEMS_DEF;
   localparam int unsigned CYCLE_LIMIT = 2_000_000;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   lis_length_per_element_top #(
      .MAX_ITEMS(MAX_ITEMS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always #5 clock = ~clock;

   // predictor state: elements of the current sequence and their run lengths
   logic signed [VALUE_W-1:0] seq_values [MAX_ITEMS];
   logic [RUN_W-1:0]          seq_lengths[MAX_ITEMS];
   int unsigned               seq_count = 0;
   rsp_type                   expected_runs[$];
   rsp_type                   oldest_run;

   int unsigned cycle_count     = 0;
   int unsigned error_count     = 0;
   int unsigned elems_sent      = 0;
   int unsigned runs_checked    = 0;
   int unsigned overflow_seen   = 0;
   int unsigned longest_run     = 0;
   int unsigned in_stall_cycles = 0;
   int unsigned held_cycles     = 0;

   // sender pacing and receiver stall control
   bit          tx_gaps    = 1'b0;
   int unsigned burst_left = 0;
   int unsigned rx_mode    = 0;
   int unsigned hold_req   = 0;
   int unsigned hold_left  = 0;
   int unsigned rx_stretch = 0;
   logic        rx_level   = 1'b1;

   function automatic rsp_type predict_run_length(input req_type elem);
      rsp_type                   r;
      int unsigned               best;
      logic signed [VALUE_W-1:0] v;
      v = elem.value;
      if (elem.first)
         seq_count = 0;
      if (seq_count >= MAX_ITEMS) begin
         r.run_length = '0;
         r.overflow   = 1'b1;
         return r;
      end
      best = 0;
      for (int unsigned k = 0; k < seq_count; k++) begin
         if (seq_values[k] < v && seq_lengths[k] > best)
            best = seq_lengths[k];
      end
      best++;
      seq_values[seq_count]  = v;
      seq_lengths[seq_count] = best[RUN_W-1:0];
      seq_count++;
      r.run_length = best[RUN_W-1:0];
      r.overflow   = 1'b0;
      return r;
   endfunction

   function automatic req_type make_elem(input logic signed [VALUE_W-1:0] v, input bit f);
      req_type e;
      e.value = v;
      e.first = f;
      return e;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // bursts of random length, random gaps between them
   task automatic pace_sender();
      if (tx_gaps) begin
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
            burst_left = $urandom_range(1, 12);
         end else begin
            burst_left--;
         end
      end
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic send_elem(input req_type elem);
      req_valid   <= 1'b1;
      req_payload <= elem;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_runs.push_back(predict_run_length(elem));
      elems_sent++;
      @(negedge clock);
      pace_sender();
   endtask

   task automatic drain_block();
      req_valid <= 1'b0;
      while (expected_runs.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed();
      rx_mode = 0;
      tx_gaps = 1'b0;
      send_elem(make_elem(32'sh8000_0000, 1'b1));
      send_elem(make_elem(32'sh7fff_ffff, 1'b0));
      send_elem(make_elem(32'sh7fff_ffff, 1'b0));   // equal value does not extend
      send_elem(make_elem(32'sh0000_0000, 1'b0));
      send_elem(make_elem(-32'sd1, 1'b0));
      send_elem(make_elem(32'sh0000_0000, 1'b0));
      send_elem(make_elem(32'sh8000_0000, 1'b0));
      send_elem(make_elem(32'sh0000_0001, 1'b0));
      send_elem(make_elem(32'sh7fff_fffe, 1'b0));
      send_elem(make_elem(32'sh0000_0005, 1'b1));   // restart mid sequence
      send_elem(make_elem(32'sh0000_0005, 1'b0));
      send_elem(make_elem(32'sh0000_0004, 1'b0));
      send_elem(make_elem(32'sh0000_0006, 1'b0));
      rx_mode = 1;
      tx_gaps = 1'b1;
      send_elem(make_elem(32'sh5555_5555, 1'b0));
      send_elem(make_elem(32'shaaaa_aaaa, 1'b0));
      send_elem(make_elem(32'sh0000_0000, 1'b1));
      send_elem(make_elem(32'sh0000_0000, 1'b0));
      send_elem(make_elem(-32'sd1, 1'b1));
      send_elem(make_elem(32'sh7fff_ffff, 1'b1));
      send_elem(make_elem(32'sh8000_0000, 1'b0));
      drain_block();
   endtask

   // strictly rising values fill the store, then the full store drops elements
   task automatic test_full_store();
      int unsigned               k;
      logic signed [VALUE_W-1:0] v;
      rx_mode = 1;
      tx_gaps = 1'b1;
      for (k = 0; k < MAX_ITEMS; k++) begin
         v = -32'sd1000000 + $signed(k * 3 + $urandom_range(0, 2));
         send_elem(make_elem(v, k == 0));
      end
      send_elem(make_elem(32'sh7fff_ffff, 1'b0));
      send_elem(make_elem(32'sh8000_0000, 1'b0));
      rx_mode = 2;
      send_elem(make_elem($urandom, 1'b0));
      send_elem(make_elem($urandom, 1'b0));
      send_elem(make_elem($urandom, 1'b1));
      send_elem(make_elem($urandom, 1'b0));
      drain_block();
   endtask

   // receiver holds off while the sender keeps offering beats
   task automatic test_backpressure();
      int unsigned k;
      rx_mode  = 0;
      tx_gaps  = 1'b0;
      hold_req = 300;
      for (k = 0; k < 24; k++)
         send_elem(make_elem($signed($urandom_range(0, 40)) - 20, k == 0));
      drain_block();
   endtask

   task automatic test_random_sequences();
      int unsigned               sent0;
      int unsigned               run_len;
      int unsigned               shape;
      int unsigned               i;
      int                        base;
      int                        step;
      logic signed [VALUE_W-1:0] v;
      bit                        f;
      sent0 = elems_sent;
      while (elems_sent - sent0 < 80) begin
         run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 25);
         shape   = $urandom_range(0, 4);
         rx_mode = $urandom_range(0, 2);
         tx_gaps = ($urandom_range(0, 2) != 0);
         base    = $urandom;
         step    = $urandom_range(0, 50);
         for (i = 0; i < run_len; i++) begin
            case (shape)
               0: v = $urandom;
               1: v = $signed($urandom_range(0, 16)) - 8;
               2: v = base + int'(i) * step + $signed($urandom_range(0, 60)) - 30;
               3: v = base - int'(i) * step + $signed($urandom_range(0, 60)) - 30;
               default: v = $signed($urandom_range(0, 1000)) - 500;
            endcase
            f = (i == 0);
            // broken sequences: stray restarts or missing ones
            if ($urandom_range(0, 19) == 0)
               f = $urandom_range(0, 1);
            send_elem(make_elem(v, f));
         end
      end
      drain_block();
   endtask

   // receiver stall pattern and long hold-off
   always @(negedge clock) begin
      if (hold_req != 0) begin
         hold_left = hold_req;
         hold_req  = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         held_cycles++;
         rsp_ready <= 1'b0;
      end else begin
         case (rx_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            default: begin
               if (rx_stretch == 0) begin
                  rx_level   = ~rx_level;
                  rx_stretch = $urandom_range(1, 6);
               end
               rx_stretch--;
               rsp_ready <= rx_level;
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_runs.size() == 0) begin
            report_mismatch($sformatf("response beat with nothing expected: run %0d ovf %0b",
                                      rsp_payload.run_length, rsp_payload.overflow));
         end else begin
            oldest_run = expected_runs.pop_front();
            if (rsp_payload.run_length !== oldest_run.run_length)
               report_mismatch($sformatf("run_length got %0d expected %0d",
                                         rsp_payload.run_length, oldest_run.run_length));
            if (rsp_payload.overflow !== oldest_run.overflow)
               report_mismatch($sformatf("overflow got %0b expected %0b",
                                         rsp_payload.overflow, oldest_run.overflow));
         end
         runs_checked++;
         if (rsp_payload.overflow === 1'b1)
            overflow_seen++;
         if (rsp_payload.run_length > longest_run)
            longest_run = rsp_payload.run_length;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (!reset && req_valid && !req_ready)
         in_stall_cycles++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats outstanding",
                  cycle_count, expected_runs.size());
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_store();
      test_backpressure();
      test_random_sequences();
      drain_block();
      repeat (MAX_ITEMS + 8) @(negedge clock);
      $display("summary: %0d elements sent, %0d responses checked, %0d overflow, longest run %0d",
               elems_sent, runs_checked, overflow_seen, longest_run);
      $display("summary: input stalled %0d cycles, receiver held off %0d cycles, %0d errors",
               in_stall_cycles, held_cycles, error_count);
      if (error_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/lis_pkg.sv
rtl/lis_length_per_element_top.sv
test/tb_lis_length_per_element_top.sv
